### rtl/fsac_pkg.sv
package fsac_pkg;

  localparam int MAX_SETS   = 256;
  localparam int MAX_WAYS   = 8;
  localparam int ADDR_WIDTH = 48;

  localparam int SET_W   = $clog2(MAX_SETS);
  localparam int WAY_W   = $clog2(MAX_WAYS);
  localparam int WAYS_W  = $clog2(MAX_WAYS + 1);
  localparam int CNT_W   = 32;
  localparam int SHIFT_W = 6;

  localparam int CFG_OFFSET_W = 5;
  localparam int CFG_INDEX_W  = 4;
  localparam int CFG_WAYS_W   = 4;

  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_SEL_W = PADDR_W - 2;

  localparam logic [REG_SEL_W-1:0] REG_OFFSET_BITS = REG_SEL_W'(0);
  localparam logic [REG_SEL_W-1:0] REG_INDEX_BITS  = REG_SEL_W'(1);
  localparam logic [REG_SEL_W-1:0] REG_WAYS_IN_USE = REG_SEL_W'(2);

  localparam logic [CFG_OFFSET_W-1:0] OFFSET_BITS_RST = CFG_OFFSET_W'(6);
  localparam logic [CFG_INDEX_W-1:0]  INDEX_BITS_RST  = CFG_INDEX_W'(0);
  localparam logic [CFG_WAYS_W-1:0]   WAYS_IN_USE_RST = CFG_WAYS_W'(1);

  typedef struct packed {
    logic [CFG_OFFSET_W-1:0] offset_bits;
    logic [CFG_INDEX_W-1:0]  index_bits;
    logic [CFG_WAYS_W-1:0]   ways_in_use;
  } cfg_t;

  // per-set bookkeeping: valid bit of each way and the FIFO replacement pointer
  typedef struct packed {
    logic [WAY_W-1:0]    ptr;
    logic [MAX_WAYS-1:0] valid;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  typedef logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_row_t;

  localparam int TAG_ROW_W = $bits(tag_row_t);

  typedef struct packed {
    logic             capture;
    logic             lookup;
    logic             update;
    logic             clear_wr;
    logic [SET_W-1:0] clr_addr;
  } cmd_t;

endpackage

### rtl/fsac_if.sv
interface fsac_req_if import fsac_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [ADDR_WIDTH-1:0] address;

  modport source (output valid, output mode, output address, input ready);
  modport sink   (input valid, input mode, input address, output ready);
endinterface

interface fsac_rsp_if import fsac_pkg::*;;
  logic             valid;
  logic             ready;
  logic             was_hit;
  logic [CNT_W-1:0] hit_count;
  logic [CNT_W-1:0] miss_count;
  logic [CNT_W-1:0] mem_read_count;
  logic [CNT_W-1:0] mem_write_count;

  modport source (output valid, output was_hit, output hit_count, output miss_count,
                  output mem_read_count, output mem_write_count, input ready);
  modport sink   (input valid, input was_hit, input hit_count, input miss_count,
                  input mem_read_count, input mem_write_count, output ready);
endinterface

### rtl/fsac_ram.sv
module fsac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/fsac_regs.sv
module fsac_regs import fsac_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [REG_SEL_W-1:0] sel;

  assign sel    = paddr[PADDR_W-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_bits <= OFFSET_BITS_RST;
      cfg.index_bits  <= INDEX_BITS_RST;
      cfg.ways_in_use <= WAYS_IN_USE_RST;
    end else if (psel && penable && pwrite) begin
      case (sel)
        REG_OFFSET_BITS: cfg.offset_bits <= pwdata[CFG_OFFSET_W-1:0];
        REG_INDEX_BITS:  cfg.index_bits  <= pwdata[CFG_INDEX_W-1:0];
        REG_WAYS_IN_USE: cfg.ways_in_use <= pwdata[CFG_WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_OFFSET_BITS: prdata = PDATA_W'(cfg.offset_bits);
      REG_INDEX_BITS:  prdata = PDATA_W'(cfg.index_bits);
      REG_WAYS_IN_USE: prdata = PDATA_W'(cfg.ways_in_use);
      default:         prdata = '0;
    endcase
  end

endmodule

### rtl/fsac_ctrl.sv
module fsac_ctrl import fsac_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR   = 4'b0001,
    S_IDLE    = 4'b0010,
    S_LOOKUP  = 4'b0100,
    S_COMPARE = 4'b1000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [SET_W-1:0] clr_addr;
  logic             slot_free;

  // the result register may be refilled in the cycle it is being taken
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.clr_addr = clr_addr;
    in_ready     = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (clr_addr == SET_W'(MAX_SETS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_COMPARE;
      end
      S_COMPARE: begin
        if (slot_free) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.clear_wr) begin
        clr_addr <= clr_addr + SET_W'(1);
      end
      if (cmd.update) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_update_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> (!out_valid || out_ready))
    else $error("result overwritten before transaction completed");

  a_accept_lookup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> cmd.lookup)
    else $error("accepted transaction not looked up");

  a_update_result: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> (out_valid && in_ready))
    else $error("update did not present a result");
`endif

endmodule

### rtl/fsac_dp.sv
module fsac_dp import fsac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  cmd_t                  cmd,
  input  logic                  in_mode,
  input  logic [ADDR_WIDTH-1:0] in_address,
  output logic                  was_hit,
  output logic [CNT_W-1:0]      hit_total,
  output logic [CNT_W-1:0]      miss_total,
  output logic [CNT_W-1:0]      read_total,
  output logic [CNT_W-1:0]      write_total
);

  logic                  mode_r;
  logic [ADDR_WIDTH-1:0] addr_r;
  logic [SET_W-1:0]      set_r;
  logic [ADDR_WIDTH-1:0] tag_r;

  logic [SHIFT_W-1:0]    tag_shift;
  logic [ADDR_WIDTH-1:0] blk;
  logic [SET_W-1:0]      set_mask;
  logic [SET_W-1:0]      set_sel;
  logic [ADDR_WIDTH-1:0] tag_sel;

  logic [META_W-1:0]    meta_rd_raw;
  logic [TAG_ROW_W-1:0] tag_rd_raw;
  meta_t                meta_rd;
  tag_row_t             tag_rd;
  meta_t                meta_new;
  tag_row_t             tag_new;

  logic [WAYS_W-1:0]   ways;
  logic [MAX_WAYS-1:0] active;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] free_vec;
  logic                hit;
  logic                has_free;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    fifo_way;
  logic [WAY_W-1:0]    fifo_ptr_next;
  logic [WAY_W-1:0]    victim;

  logic                meta_we;
  logic [SET_W-1:0]    meta_wa;
  logic [META_W-1:0]   meta_wd;
  logic                tag_we;

  // address split
  always_comb begin
    tag_shift = SHIFT_W'(cfg.offset_bits) + SHIFT_W'(cfg.index_bits);
    blk       = addr_r >> cfg.offset_bits;
    tag_sel   = addr_r >> tag_shift;
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (CFG_INDEX_W'(i) < cfg.index_bits);
    end
    set_sel = blk[SET_W-1:0] & set_mask;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      addr_r <= in_address;
    end
    if (cmd.lookup) begin
      set_r <= set_sel;
      tag_r <= tag_sel;
    end
  end

  assign meta_rd = meta_t'(meta_rd_raw);
  assign tag_rd  = tag_row_t'(tag_rd_raw);

  // way compare and victim choice
  always_comb begin
    if (cfg.ways_in_use == '0) begin
      ways = WAYS_W'(1);
    end else if (WAYS_W'(cfg.ways_in_use) > WAYS_W'(MAX_WAYS)) begin
      ways = WAYS_W'(MAX_WAYS);
    end else begin
      ways = WAYS_W'(cfg.ways_in_use);
    end

    for (int w = 0; w < MAX_WAYS; w++) begin
      active[w]   = (WAYS_W'(w) < ways);
      hit_vec[w]  = active[w] && meta_rd.valid[w] && (tag_rd[w] == tag_r);
      free_vec[w] = active[w] && !meta_rd.valid[w];
    end
    hit      = |hit_vec;
    has_free = |free_vec;

    free_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (free_vec[w]) begin
        free_way = WAY_W'(w);
      end
    end

    // a stale pointer past the ways in use restarts at way zero
    fifo_way = (WAYS_W'(meta_rd.ptr) >= ways) ? '0 : meta_rd.ptr;
    fifo_ptr_next = ((WAYS_W'(fifo_way) + WAYS_W'(1)) >= ways) ? '0 : fifo_way + WAY_W'(1);

    victim = has_free ? free_way : fifo_way;

    meta_new.ptr = has_free ? meta_rd.ptr : fifo_ptr_next;
    for (int w = 0; w < MAX_WAYS; w++) begin
      meta_new.valid[w] = meta_rd.valid[w] || (victim == WAY_W'(w));
    end

    tag_new         = tag_rd;
    tag_new[victim] = tag_r;
  end

  assign tag_we  = cmd.update && !hit;
  assign meta_we = cmd.clear_wr || tag_we;
  assign meta_wa = cmd.clear_wr ? cmd.clr_addr : set_r;
  assign meta_wd = cmd.clear_wr ? '0 : META_W'(meta_new);

  fsac_ram #(
    .WIDTH (META_W),
    .DEPTH (MAX_SETS)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_we),
    .wr_addr (meta_wa),
    .wr_data (meta_wd),
    .rd_en   (cmd.lookup),
    .rd_addr (set_sel),
    .rd_data (meta_rd_raw)
  );

  fsac_ram #(
    .WIDTH (TAG_ROW_W),
    .DEPTH (MAX_SETS)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (tag_we),
    .wr_addr (set_r),
    .wr_data (TAG_ROW_W'(tag_new)),
    .rd_en   (cmd.lookup),
    .rd_addr (set_sel),
    .rd_data (tag_rd_raw)
  );

  // running totals, held at their maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total   <= '0;
      miss_total  <= '0;
      read_total  <= '0;
      write_total <= '0;
    end else if (cmd.update) begin
      if (hit) begin
        if (hit_total != '1) hit_total <= hit_total + CNT_W'(1);
      end else begin
        if (miss_total != '1) miss_total <= miss_total + CNT_W'(1);
        if (read_total != '1) read_total <= read_total + CNT_W'(1);
      end
      if (mode_r && (write_total != '1)) begin
        write_total <= write_total + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      was_hit <= hit;
    end
  end

`ifndef SYNTHESIS
  a_miss_read_match: assert property (@(posedge clk) disable iff (rst)
    miss_total == read_total)
    else $error("miss and memory read totals diverged");

  a_totals_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.update |=> ($stable(hit_total) && $stable(miss_total) && $stable(write_total)))
    else $error("totals moved without an update");
`endif

endmodule

### rtl/fifo_set_assoc_cache_model_unit.sv
// Set-associative cache model, FIFO replacement, write-through.
// req (sink): one transaction per access, mode 0 read / 1 write, 48-bit byte
// address. rsp (source): hit flag plus saturating totals of hits, misses,
// memory block reads and memory writes, one transaction per access.
// The APB port sets offset_bits (0x0), index_bits (0x4) and ways_in_use (0x8);
// write it only while no access is in flight.
// Timing: an accepted access is captured, then looked up in the per-set tag and
// meta memories through their registered read, then compared; the result is
// registered at the compare and write-back step. A new access is accepted only
// after the current one has left that step.
// Reset: restores the configuration defaults and clears the totals, then a
// clearing pass zeroes the valid bits and FIFO pointers of every set, one set a
// cycle; req.ready stays low throughout. Tags are not cleared.
// Stall: a result waits in its output register while rsp.ready is low; one
// further access is accepted and held at the compare step until the waiting
// result is taken.
module fifo_set_assoc_cache_model_unit import fsac_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  fsac_req_if.sink           req,
  fsac_rsp_if.source         rsp
);

  cfg_t cfg;
  cmd_t cmd;

  fsac_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fsac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  fsac_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .in_mode     (req.mode),
    .in_address  (req.address),
    .was_hit     (rsp.was_hit),
    .hit_total   (rsp.hit_count),
    .miss_total  (rsp.miss_count),
    .read_total  (rsp.mem_read_count),
    .write_total (rsp.mem_write_count)
  );

endmodule

### tb/fifo_set_assoc_cache_model_unit_checker.sv
module fifo_set_assoc_cache_model_unit_checker import fsac_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  fsac_req_if                req,
  fsac_rsp_if                rsp,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             was_hit;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CNT_W-1:0] mem_read_count;
    logic [CNT_W-1:0] mem_write_count;
  } access_result_t;

  cfg_t                  cfg;
  logic                  line_ok    [MAX_SETS][MAX_WAYS];
  logic [ADDR_WIDTH-1:0] line_tag_q [MAX_SETS][MAX_WAYS];
  logic [WAY_W-1:0]      evict_ptr  [MAX_SETS];
  logic [CNT_W-1:0]      hits, misses, blk_reads, mem_writes;
  access_result_t        expected_results [$];
  int                    errors = 0;
  int                    outstanding = 0;

  assign fail_count = errors;
  assign pending    = outstanding;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Look the access up, update the line store and totals, return the result
  function automatic access_result_t lookup_and_fill(input logic is_write,
                                                     input logic [ADDR_WIDTH-1:0] addr);
    logic [ADDR_WIDTH-1:0] blk;
    logic [ADDR_WIDTH-1:0] tag;
    logic [SET_W-1:0]      set_idx;
    int                    nways;
    int                    free_way;
    int                    victim;
    logic                  hit;
    blk     = addr >> cfg.offset_bits;
    set_idx = SET_W'(blk & ((ADDR_WIDTH'(1) << cfg.index_bits) - 1'b1));
    tag     = addr >> (int'(cfg.offset_bits) + int'(cfg.index_bits));
    nways   = int'(cfg.ways_in_use);
    if (nways == 0) begin
      nways = 1;
    end else if (nways > MAX_WAYS) begin
      nways = MAX_WAYS;
    end
    hit      = 1'b0;
    free_way = -1;
    for (int w = 0; w < nways; w++) begin
      if (line_ok[set_idx][w]) begin
        if (line_tag_q[set_idx][w] == tag) hit = 1'b1;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    if (hit) begin
      hits = sat_inc(hits);
    end else begin
      misses    = sat_inc(misses);
      blk_reads = sat_inc(blk_reads);
      if (free_way >= 0) begin
        victim = free_way;
      end else begin
        // a pointer left over from a wider setting restarts at way 0
        victim = int'(evict_ptr[set_idx]);
        if (victim >= nways) victim = 0;
        evict_ptr[set_idx] = (victim + 1 >= nways) ? '0 : WAY_W'(victim + 1);
      end
      line_ok[set_idx][victim]    = 1'b1;
      line_tag_q[set_idx][victim] = tag;
    end
    if (is_write) mem_writes = sat_inc(mem_writes);
    return '{hit, hits, misses, blk_reads, mem_writes};
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] exp_v,
                             input logic [CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    access_result_t exp_r;
    if (rst) begin
      cfg = '{OFFSET_BITS_RST, INDEX_BITS_RST, WAYS_IN_USE_RST};
      foreach (line_ok[s, w]) line_ok[s][w] = 1'b0;
      foreach (evict_ptr[s]) evict_ptr[s] = '0;
      hits       = '0;
      misses     = '0;
      blk_reads  = '0;
      mem_writes = '0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_OFFSET_BITS: cfg.offset_bits = pwdata[CFG_OFFSET_W-1:0];
          REG_INDEX_BITS:  cfg.index_bits  = pwdata[CFG_INDEX_W-1:0];
          REG_WAYS_IN_USE: cfg.ways_in_use = pwdata[CFG_WAYS_W-1:0];
          default: ;
        endcase
      end
      // compare before predicting: a new access cannot answer in its own cycle
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual hit=%0d hits=%0d",
                   $time, rsp.was_hit, rsp.hit_count);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("was_hit", CNT_W'(exp_r.was_hit), CNT_W'(rsp.was_hit));
          check_field("hit_count", exp_r.hit_count, rsp.hit_count);
          check_field("miss_count", exp_r.miss_count, rsp.miss_count);
          check_field("mem_read_count", exp_r.mem_read_count, rsp.mem_read_count);
          check_field("mem_write_count", exp_r.mem_write_count, rsp.mem_write_count);
        end
      end
      if (req.valid && req.ready) begin
        expected_results.push_back(lookup_and_fill(req.mode, req.address));
      end
    end
    outstanding = expected_results.size();
  end

endmodule

### tb/fifo_set_assoc_cache_model_unit_tb.sv
module fifo_set_assoc_cache_model_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fsac_pkg::*;

  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;
  int                 cur_off;
  int                 cur_idx;

  fsac_req_if req_if();
  fsac_rsp_if rsp_if();

  fifo_set_assoc_cache_model_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_if),
    .rsp     (rsp_if)
  );

  fifo_set_assoc_cache_model_unit_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .req        (req_if),
    .rsp        (rsp_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: switch between always ready, random ready and long stalls
  initial begin
    int phase;
    int phase_left;
    int hold;
    rsp_if.ready = 1'b0;
    phase      = 0;
    phase_left = 0;
    hold       = 0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        phase      = $urandom_range(0, 2);
        phase_left = $urandom_range(20, 200);
      end else begin
        phase_left--;
      end
      case (phase)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            hold--;
          end else begin
            rsp_if.ready <= 1'b1;
            hold = $urandom_range(1, 20);
          end
        end
      endcase
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_access(input logic m, input logic [ADDR_WIDTH-1:0] a);
    req_if.valid   <= 1'b1;
    req_if.mode    <= m;
    req_if.address <= a;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_SEL_W-1:0] sel, input logic [PDATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // upper bits are noise: the block keeps only the register's own width
  task automatic configure(input int off, input int idx, input int ways);
    logic [PDATA_W-1:0] d;
    wait_idle();
    d = $urandom;
    d[CFG_OFFSET_W-1:0] = CFG_OFFSET_W'(off);
    write_reg(REG_OFFSET_BITS, d);
    d = $urandom;
    d[CFG_INDEX_W-1:0] = CFG_INDEX_W'(idx);
    write_reg(REG_INDEX_BITS, d);
    d = $urandom;
    d[CFG_WAYS_W-1:0] = CFG_WAYS_W'(ways);
    write_reg(REG_WAYS_IN_USE, d);
    cur_off = off;
    cur_idx = idx;
  endtask

  // mostly reuse a small pool of tags on a few sets so that hits and evictions occur
  task automatic run_random(input int n_items);
    logic [ADDR_WIDTH-1:0] tag_pool [16];
    logic [ADDR_WIDTH-1:0] tag_v;
    logic [ADDR_WIDTH-1:0] set_v;
    logic [ADDR_WIDTH-1:0] off_v;
    logic [ADDR_WIDTH-1:0] addr_v;
    int                    pool_n;
    int                    burst_left;
    int                    pause_at;
    pool_n = $urandom_range(1, 16);
    foreach (tag_pool[k]) tag_pool[k] = ADDR_WIDTH'({$urandom, $urandom});
    burst_left = $urandom_range(1, 30);
    pause_at   = $urandom_range(0, n_items - 1);
    for (int i = 0; i < n_items; i++) begin
      if (i == pause_at) begin
        wait_idle();
      end else if (burst_left == 0) begin
        req_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 30);
      end
      if (burst_left > 0) burst_left--;
      if ($urandom_range(0, 4) == 0) begin
        addr_v = ADDR_WIDTH'({$urandom, $urandom});
      end else begin
        tag_v = tag_pool[$urandom_range(0, pool_n - 1)] << (cur_off + cur_idx);
        set_v = ADDR_WIDTH'($urandom_range(0, 3));
        // alias sets beyond the built ones
        if ($urandom_range(0, 3) == 0) set_v = set_v + ADDR_WIDTH'(256 * $urandom_range(1, 127));
        set_v = (set_v & ((ADDR_WIDTH'(1) << cur_idx) - 1'b1)) << cur_off;
        off_v = ADDR_WIDTH'({$urandom, $urandom}) & ((ADDR_WIDTH'(1) << cur_off) - 1'b1);
        addr_v = tag_v | set_v | off_v;
      end
      send_access(1'($urandom_range(0, 1)), addr_v);
    end
  endtask

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_if.valid   = 1'b0;
    req_if.mode    = ACC_READ;
    req_if.address = '0;
    cur_off        = int'(OFFSET_BITS_RST);
    cur_idx        = int'(INDEX_BITS_RST);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset setting: 64-byte blocks, one set, one way
    send_access(ACC_READ, 48'h0);
    send_access(ACC_WRITE, 48'h0);
    send_access(ACC_READ, 48'h3F);
    send_access(ACC_READ, 48'h40);
    send_access(ACC_READ, 48'h0);
    send_access(ACC_WRITE, 48'hFFFF_FFFF_FFFF);
    send_access(ACC_READ, 48'hFFFF_FFFF_FFC0);

    // zero ways behaves as one way, byte-sized blocks
    configure(0, 0, 0);
    send_access(ACC_READ, 48'h1);
    send_access(ACC_READ, 48'h1);
    send_access(ACC_WRITE, 48'h2);

    // ways above the built count saturate; fill set 0 then evict in FIFO order
    configure(4, 2, 15);
    for (int t = 0; t < 9; t++) send_access(1'(t), ADDR_WIDTH'(t) << 6);
    send_access(ACC_READ, 48'h0);

    // shrink: pointer beyond the ways in use restarts, upper ways ignored
    configure(4, 2, 2);
    send_access(ACC_READ, ADDR_WIDTH'(9) << 6);
    send_access(ACC_WRITE, ADDR_WIDTH'(3) << 6);

    // widen again: upper ways still hold their lines
    configure(4, 2, 8);
    send_access(ACC_READ, ADDR_WIDTH'(3) << 6);
    send_access(ACC_READ, ADDR_WIDTH'(5) << 6);

    configure(31, 15, 8);
    run_random(140);
    configure(0, 8, 8);
    run_random(140);
    configure(16, 8, 4);
    run_random(140);
    configure(0, 0, 1);
    run_random(140);
    configure(5, 3, 3);
    run_random(140);
    configure(31, 0, 15);
    run_random(140);
    configure(6, 15, 2);
    run_random(140);
    repeat (5) begin
      configure($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 15));
      run_random(140);
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### fifo_set_assoc_cache_model_unit.f
rtl/fsac_pkg.sv
rtl/fsac_if.sv
rtl/fsac_ram.sv
rtl/fsac_regs.sv
rtl/fsac_ctrl.sv
rtl/fsac_dp.sv
rtl/fifo_set_assoc_cache_model_unit.sv
tb/fifo_set_assoc_cache_model_unit_checker.sv
tb/fifo_set_assoc_cache_model_unit_tb.sv
